### src/sha256bs_pkg.sv
// Shared types, constants and round-constant table for the SHA-256 byte-stream hasher.
`timescale 1ns / 1ps
package sha256bs_pkg;

  localparam int unsigned BLOCK_BITS = 512;
  localparam int unsigned WORD_BITS  = 32;

  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [1:0] PART_LAST = 2'd3;
  localparam logic [5:0] ROUND_LAST = 6'd63;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_OUT
  } state_t;

  // working variables a..h of one compression
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    logic [31:0] f;
    logic [31:0] g;
    logic [31:0] h;
  } work_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (WORD_BITS - n));
  endfunction

endpackage

### src/sha256bs_round.sv
// One SHA-256 round plus one message-schedule step, reused for all 64 rounds.
`timescale 1ns / 1ps
module sha256bs_round
  import sha256bs_pkg::*;
(
  input  work_t       work,
  input  logic [31:0] kt,
  input  logic [31:0] w0,
  input  logic [31:0] w1,
  input  logic [31:0] w9,
  input  logic [31:0] w14,
  output work_t       work_next,
  output logic [31:0] w_new
);

  logic [31:0] big0, big1, ch, maj, t1, t2, sig0, sig1;

  always_comb begin
    big1 = rotr(work.e, 6) ^ rotr(work.e, 11) ^ rotr(work.e, 25);
    ch   = (work.e & work.f) ^ (~work.e & work.g);
    t1   = work.h + big1 + ch + kt + w0;
    big0 = rotr(work.a, 2) ^ rotr(work.a, 13) ^ rotr(work.a, 22);
    maj  = (work.a & work.b) ^ (work.a & work.c) ^ (work.b & work.c);
    t2   = big0 + maj;

    work_next.h = work.g;
    work_next.g = work.f;
    work_next.f = work.e;
    work_next.e = work.d + t1;
    work_next.d = work.c;
    work_next.c = work.b;
    work_next.b = work.a;
    work_next.a = t1 + t2;

    // schedule word sixteen ahead of the current one
    sig0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    sig1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    w_new = sig1 + w9 + sig0 + w0;
  end

endmodule

### src/sha256_byte_stream_hash.sv
// SHA-256 byte-stream hasher: byte buffer, padding sequencer and iterative round unit.
// Append: a byte is taken only while idle; the last byte of a block starts the rounds
// and the hash update, during which s_tready is low. Finish at buffer position p:
// padding bytes complete the block, then the rounds and hash update run, and again for
// a second padding block when p >= 56; then four digest transactions, one per cycle
// while m_tready is high. All cost is set by the single round unit, one round per cycle.
// rst (synchronous) restores the initial hash values and empties the buffer.
`timescale 1ns / 1ps
module sha256_byte_stream_hash
  import sha256bs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] digest_part
  output logic [1:0]  m_tuser,   // [1:0] part_index
  output logic        m_tlast
);

  state_t state, state_next;

  logic [BLOCK_BITS-1:0] blk;
  logic [5:0]   fill;
  logic [54:0]  blk_cnt;
  logic [63:0]  total_len;
  logic         two_blk;
  logic         mark_done;
  logic         finishing;
  logic [5:0]   rnd;
  logic [1:0]   part;
  logic [31:0]  hash [8];
  work_t        work, work_next;
  logic [31:0]  w_new;

  logic         acc;
  logic         shift_en;
  logic [7:0]   pad_byte;
  logic [7:0]   shift_byte;
  logic         out_acc;

  sha256bs_round u_round (
    .work      (work),
    .kt        (round_k(rnd)),
    .w0        (blk[511:480]),
    .w1        (blk[479:448]),
    .w9        (blk[223:192]),
    .w14       (blk[63:32]),
    .work_next (work_next),
    .w_new     (w_new)
  );

  always_comb begin
    s_tready = (state == ST_IDLE);
    acc      = s_tvalid && s_tready;
    out_acc  = m_tvalid && m_tready;

    if (!mark_done) begin
      pad_byte = PAD_MARK;
    end else if (fill >= LEN_POS && !two_blk) begin
      pad_byte = total_len[{~fill[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end

    shift_en   = (acc && cmd_t'(s_tuser[0]) == CMD_APPEND) || (state == ST_PAD);
    shift_byte = (state == ST_PAD) ? pad_byte : s_tdata;

    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          if (cmd_t'(s_tuser[0]) == CMD_FINISH) begin
            state_next = ST_PAD;
          end else if (fill == FILL_LAST) begin
            state_next = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        if (rnd == ROUND_LAST) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (finishing && two_blk) begin
          state_next = ST_PAD;
        end else if (finishing) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (fill == FILL_LAST) state_next = ST_ROUND;
      end
      ST_OUT: begin
        if (out_acc && part == PART_LAST) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      blk_cnt   <= '0;
      two_blk   <= 1'b0;
      mark_done <= 1'b0;
      finishing <= 1'b0;
      rnd       <= '0;
      part      <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= H_INIT[i];
    end else begin
      if (shift_en) fill <= fill + 6'd1;
      if (state == ST_PAD) mark_done <= 1'b1;
      if (acc && cmd_t'(s_tuser[0]) == CMD_FINISH) begin
        two_blk   <= (fill >= LEN_POS);
        mark_done <= 1'b0;
        finishing <= 1'b1;
      end
      if (state == ST_ROUND) begin
        rnd <= rnd + 6'd1;
      end else begin
        rnd <= '0;
      end
      if (state == ST_UPDATE) begin
        hash[0] <= hash[0] + work.a;
        hash[1] <= hash[1] + work.b;
        hash[2] <= hash[2] + work.c;
        hash[3] <= hash[3] + work.d;
        hash[4] <= hash[4] + work.e;
        hash[5] <= hash[5] + work.f;
        hash[6] <= hash[6] + work.g;
        hash[7] <= hash[7] + work.h;
        if (!finishing) blk_cnt <= blk_cnt + 55'd1;
        if (finishing) two_blk <= 1'b0;
      end
      if (out_acc) begin
        part <= part + 2'd1;
        if (part == PART_LAST) begin
          fill      <= '0;
          blk_cnt   <= '0;
          finishing <= 1'b0;
          for (int i = 0; i < 8; i++) hash[i] <= H_INIT[i];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (shift_en) begin
      blk <= {blk[BLOCK_BITS-9:0], shift_byte};
    end else if (state == ST_ROUND) begin
      blk <= {blk[BLOCK_BITS-WORD_BITS-1:0], w_new};
    end
    if (acc && cmd_t'(s_tuser[0]) == CMD_FINISH) begin
      total_len <= {blk_cnt, fill, 3'b000};
    end
    if (state_next == ST_ROUND && state != ST_ROUND) begin
      work <= {hash[0], hash[1], hash[2], hash[3], hash[4], hash[5], hash[6], hash[7]};
    end else if (state == ST_ROUND) begin
      work <= work_next;
    end
  end

  always_comb begin
    m_tvalid = (state == ST_OUT);
    m_tdata  = {hash[{part, 1'b0}], hash[{part, 1'b1}]};
    m_tuser  = part;
    m_tlast  = (part == PART_LAST);
  end

endmodule

### src/sha256bs_checker.sv
// Port-level checks for the SHA-256 byte-stream hasher, bound to the top level.
`timescale 1ns / 1ps
module sha256bs_checker
  import sha256bs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // no input is taken while a digest is being delivered
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("input ready while digest pending");

  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> (m_tlast == (m_tuser == PART_LAST)))
    else $error("tlast does not match final part index");

  // parts come out in order, back to back after each transaction
  assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tuser == $past(m_tuser) + 2'd1))
    else $error("digest parts out of order");

  assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled digest part changed");

  assert property (@(posedge clk) $past(rst) && !rst |-> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind sha256_byte_stream_hash sha256bs_checker u_sha256bs_checker (.*);

### tb/testbench.sv
// Self-checking testbench for the SHA-256 byte-stream hasher, with its own digest predictor.
`timescale 1ns / 1ps
module testbench;
  import sha256bs_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned ITEM_TARGET = 450;
  localparam int unsigned DRAIN_CYCLES = 300;

  localparam logic [31:0] ROUND_WORDS [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [63:0] part;
    logic [1:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic [0:0]  s_tuser = 1'b0;    // [0] cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;           // [63:0] digest_part
  logic [1:0]  m_tuser;           // [1:0] part_index
  logic        m_tlast;

  // predictor state
  logic [7:0]  msg_block [64];
  int unsigned block_fill;
  logic [63:0] msg_bit_count;
  logic [31:0] chain_hash [8];

  digest_beat_t digest_parts_due [$];

  bit          quiet_run = 1'b0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned messages_hashed = 0;
  int unsigned bytes_hashed = 0;
  int unsigned spill_finishes = 0;
  int unsigned beats_checked = 0;

  sha256_byte_stream_hash u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic void restart_digest();
    block_fill = 0;
    msg_bit_count = '0;
    for (int i = 0; i < 8; i++) chain_hash[i] = START_HASH[i];
  endfunction

  function automatic void compress_msg_block();
    logic [31:0] w [64];
    logic [31:0] wv [8];
    logic [31:0] s0, s1, t1, t2, ch, maj;
    for (int r = 0; r < 16; r++)
      w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
    for (int r = 16; r < 64; r++) begin
      s0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = s1 + w[r-7] + s0 + w[r-16];
    end
    for (int i = 0; i < 8; i++) wv[i] = chain_hash[i];
    for (int r = 0; r < 64; r++) begin
      s1 = ror32(wv[4], 6) ^ ror32(wv[4], 11) ^ ror32(wv[4], 25);
      ch = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
      t1 = wv[7] + s1 + ch + ROUND_WORDS[r] + w[r];
      s0 = ror32(wv[0], 2) ^ ror32(wv[0], 13) ^ ror32(wv[0], 22);
      maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
      t2 = s0 + maj;
      wv[7] = wv[6]; wv[6] = wv[5]; wv[5] = wv[4]; wv[4] = wv[3] + t1;
      wv[3] = wv[2]; wv[2] = wv[1]; wv[1] = wv[0]; wv[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_hash[i] = chain_hash[i] + wv[i];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    msg_block[block_fill] = b;
    block_fill++;
    bytes_hashed++;
    if (block_fill == 64) begin
      compress_msg_block();
      msg_bit_count = msg_bit_count + 64'd512;
      block_fill = 0;
    end
  endfunction

  function automatic void finish_digest();
    logic [63:0] total;
    digest_beat_t beat;
    total = msg_bit_count + 64'(block_fill) * 64'd8;
    msg_block[block_fill] = 8'h80;
    if (block_fill < 56) begin
      for (int i = block_fill + 1; i < 56; i++) msg_block[i] = 8'h00;
    end else begin
      // length no longer fits: spill into a second padding block
      for (int i = block_fill + 1; i < 64; i++) msg_block[i] = 8'h00;
      compress_msg_block();
      for (int i = 0; i < 56; i++) msg_block[i] = 8'h00;
      spill_finishes++;
    end
    for (int k = 0; k < 8; k++) msg_block[56+k] = total[63-8*k -: 8];
    compress_msg_block();
    for (int k = 0; k < 4; k++) begin
      beat.part = {chain_hash[2*k], chain_hash[2*k+1]};
      beat.idx  = 2'(k);
      beat.last = (k == 3);
      digest_parts_due.push_back(beat);
    end
    messages_hashed++;
    restart_digest();
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_run || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input cmd_t c, input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (c == CMD_FINISH) finish_digest();
    else absorb_byte(b);
    @(negedge clk);
  endtask

  task automatic send_message(input int unsigned len, input bit calm);
    quiet_run = calm;
    for (int unsigned i = 0; i < len; i++) send_item(CMD_APPEND, 8'($urandom_range(0, 255)));
    // data_byte is don't-care on finish, so drive noise there
    send_item(CMD_FINISH, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_reference_strings();
    quiet_run = 1'b0;
    send_item(CMD_FINISH, 8'h00);                 // empty message
    send_item(CMD_APPEND, 8'h61);
    send_item(CMD_APPEND, 8'h62);
    send_item(CMD_APPEND, 8'h63);
    send_item(CMD_FINISH, 8'h00);                 // "abc"
    send_item(CMD_FINISH, 8'hff);                 // back-to-back finish, ignored byte set
    send_item(CMD_APPEND, 8'h00);
    send_item(CMD_FINISH, 8'hff);
    send_item(CMD_APPEND, 8'hff);
    send_item(CMD_APPEND, 8'h00);
    send_item(CMD_FINISH, 8'h00);
  endtask

  // last length that fits one block, first that spills, exact block
  task automatic test_padding_boundaries();
    send_message(55, 1'b0);
    send_message(56, 1'b1);
    send_message(64, 1'b0);
  endtask

  task automatic test_random_messages();
    int unsigned r, len;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 50) len = $urandom_range(0, 8);
      else if (r < 70) len = 54 + $urandom_range(0, 11);
      else len = $urandom_range(0, 130);
      send_message(len, $urandom_range(0, 4) == 0);
    end
  endtask

  // downstream backpressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (quiet_run) begin
      m_tready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 99) < 65) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b0;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    digest_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (digest_parts_due.size() == 0) begin
        $error("digest transaction with nothing expected: tdata=%h tuser=%0d tlast=%0b",
               m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        want = digest_parts_due.pop_front();
        beats_checked++;
        if (m_tdata !== want.part) begin
          $error("digest_part: expected %h, got %h", want.part, m_tdata);
          errors++;
        end
        if (m_tuser !== want.idx) begin
          $error("part_index: expected %0d, got %0d", want.idx, m_tuser);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last_part: expected %0b, got %0b", want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // hang detector: cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("sha256_byte_stream_hash verification failed");
        $finish;
      end
    end
  end

  initial begin
    restart_digest();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reference_strings();
    test_padding_boundaries();
    test_random_messages();
    s_tvalid <= 1'b0;

    quiet_run = 1'b0;
    while (digest_parts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("hashed %0d messages, %0d bytes, %0d finishes needing a spill block",
             messages_hashed, bytes_hashed, spill_finishes);
    $display("%0d items sent, %0d digest parts compared, %0d errors",
             items_sent, beats_checked, errors);
    if (errors == 0) begin
      $display("sha256_byte_stream_hash verification clean");
    end else begin
      $display("sha256_byte_stream_hash verification failed");
    end
    $finish;
  end

endmodule

### files.f
src/sha256bs_pkg.sv
src/sha256bs_round.sv
src/sha256_byte_stream_hash.sv
src/sha256bs_checker.sv
tb/testbench.sv
